// ----- rtl/ulf_pkg.sv -----
// ulf_pkg: shared constants for the UART line framer.
// Used by uart_line_framer, ulf_front, ulf_back and the testbench; depends on nothing.
package ulf_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int MAX_LINE_DEF = 31;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

endpackage

// ----- rtl/uart_line_framer.sv -----
// uart_line_framer: top level of the newline-delimited line framer.
// Uses ulf_pkg, ulf_front, ulf_queue, ulf_back and ulf_ram.
// Throughput: one received byte per cycle while a line store bank is free;
// a completed line replays byte by byte (RAM read, then output, held by out_ready).
// The first byte of a line appears after its line feed has passed the queue and a RAM read.
// Reset clears counters, queue and replay state; the RAM is not cleared.
module uart_line_framer #(
  parameter int MAX_LINE = ulf_pkg::MAX_LINE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ulf_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       in_forward_enable,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ulf_pkg::BYTE_W-1:0] out_line_byte,
  output logic [ulf_pkg::IDX_W-1:0]  out_byte_index,
  output logic                       out_last_byte
);
  import ulf_pkg::*;

  // Count width holds 0..MAX_LINE; the RAM holds two banks of MAX_LINE bytes,
  // so the front can fill one line while the back replays the other.
  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int AW = $clog2(2 * MAX_LINE);

  logic             q_full, q_push, q_pop, q_valid;
  logic [CW:0]      q_push_data, q_head;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  // The front classifies each byte: carriage returns are skipped, line feeds
  // close the line and, when it is not empty and forwarding is on, hand a descriptor to the queue.
  ulf_front #(.MAX_LINE(MAX_LINE), .CW(CW), .AW(AW)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_forward_enable (in_forward_enable),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_push_data       (q_push_data),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data)
  );

  // A descriptor stays at the head until its last byte is taken, so the
  // queue fill equals the number of banks in use.
  ulf_queue #(.WIDTH(CW + 1)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .full       (q_full)
  );

  ulf_ram #(.WIDTH(BYTE_W), .DEPTH(2 * MAX_LINE), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The back walks the head line byte by byte and holds each result in its
  // output register until the downstream side takes it.
  ulf_back #(.MAX_LINE(MAX_LINE), .CW(CW), .AW(AW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_byte  (out_line_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ----- rtl/ulf_ram.sv -----
// ulf_ram: generic single-write, single-read RAM with a registered read.
// Stands alone; width and depth are set by parameters.
module ulf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ulf_front.sv -----
// ulf_front: accepts received bytes, classifies them and fills the line store.
// Uses ulf_pkg; writes the RAM and pushes finished line descriptors to ulf_queue.
module ulf_front #(
  parameter int MAX_LINE = ulf_pkg::MAX_LINE_DEF,
  parameter int CW = $clog2(MAX_LINE + 1),
  parameter int AW = $clog2(2 * MAX_LINE)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ulf_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                      in_forward_enable,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [CW:0]               q_push_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [ulf_pkg::BYTE_W-1:0] wr_data
);
  import ulf_pkg::*;

  logic [CW-1:0] count_r, count_nxt;
  logic          bank_r, bank_nxt;
  logic          accept;

  // Both banks are taken while two lines wait for replay.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign wr_data  = in_rx_byte;
  assign wr_addr  = bank_r ? (AW'(MAX_LINE) + AW'(count_r)) : AW'(count_r);
  assign q_push_data = {bank_r, count_r};

  always_comb begin
    count_nxt = count_r;
    bank_nxt  = bank_r;
    q_push    = 1'b0;
    wr_en     = 1'b0;
    if (accept) begin
      if (in_rx_byte == CHAR_LF) begin
        if (count_r != '0 && in_forward_enable) begin
          q_push   = 1'b1;
          bank_nxt = !bank_r;
        end
        count_nxt = '0;
      end else if (in_rx_byte != CHAR_CR) begin
        if (count_r < CW'(MAX_LINE)) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// ----- rtl/ulf_queue.sv -----
// ulf_queue: two-entry queue of line descriptors (bank and length).
// Stands alone; sits between ulf_front and ulf_back.
module ulf_queue #(
  parameter int WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;

  assign head_valid = (fill_r != 2'd0);
  assign full       = (fill_r == 2'd2);
  assign head_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("ulf_queue: push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("ulf_queue: pop while empty");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("ulf_queue: fill count out of range");

endmodule

// ----- rtl/ulf_back.sv -----
// ulf_back: replays a stored line from the RAM, one byte per output request.
// Uses ulf_pkg; reads line descriptors from ulf_queue and the RAM read port.
module ulf_back #(
  parameter int MAX_LINE = ulf_pkg::MAX_LINE_DEF,
  parameter int CW = $clog2(MAX_LINE + 1),
  parameter int AW = $clog2(2 * MAX_LINE)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [CW:0]                q_data,
  output logic                       q_pop,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [ulf_pkg::BYTE_W-1:0] rd_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ulf_pkg::BYTE_W-1:0] out_line_byte,
  output logic [ulf_pkg::IDX_W-1:0]  out_byte_index,
  output logic                       out_last_byte
);
  import ulf_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_WAIT, B_SHOW} back_state_t;

  back_state_t      state_r;
  logic [CW-1:0]    idx_r, len_r;
  logic             bank_r;
  logic [BYTE_W-1:0] byte_r;
  logic             last_r;
  logic             rd_bank;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    idx_inc;

  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    rd_en   = 1'b0;
    rd_bank = bank_r;
    rd_idx  = idx_inc;
    q_pop   = 1'b0;
    case (state_r)
      B_IDLE: begin
        rd_en   = q_valid;
        rd_bank = q_data[CW];
        rd_idx  = '0;
      end
      B_SHOW: begin
        if (out_ready) begin
          rd_en = !last_r;
          q_pop = last_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = rd_bank ? (AW'(MAX_LINE) + AW'(rd_idx)) : AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
      bank_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            idx_r   <= '0;
            len_r   <= q_data[CW-1:0];
            bank_r  <= q_data[CW];
            state_r <= B_WAIT;
          end
        end
        B_WAIT: begin
          byte_r  <= rd_data;
          last_r  <= (idx_inc == len_r);
          state_r <= B_SHOW;
        end
        B_SHOW: begin
          if (out_ready) begin
            if (last_r) begin
              state_r <= B_IDLE;
            end else begin
              idx_r   <= idx_inc;
              state_r <= B_WAIT;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = (state_r == B_SHOW);
  assign out_line_byte  = byte_r;
  assign out_byte_index = IDX_W'(idx_r);
  assign out_last_byte  = last_r;

endmodule

// ----- verif/ulf_line_checker.sv -----
// ulf_line_checker: watches both channels of uart_line_framer, predicts each line and checks it.
// Depends on ulf_pkg for the byte and index widths and the CR and LF codes.
`timescale 1ns / 1ps

module ulf_line_checker #(
  parameter int MAX_LINE = ulf_pkg::MAX_LINE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ulf_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       in_forward_enable,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ulf_pkg::BYTE_W-1:0] out_line_byte,
  input  logic [ulf_pkg::IDX_W-1:0]  out_byte_index,
  input  logic                       out_last_byte,
  output int                         fail_count,
  output int                         pending_count,
  output int                         lines_forwarded,
  output int                         bytes_checked
);
  import ulf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
  } framed_byte_t;

  logic [BYTE_W-1:0] held_line [MAX_LINE];
  int unsigned       held_count;
  framed_byte_t      expected_bytes [$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    lines_forwarded = 0;
    bytes_checked   = 0;
    held_count      = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] framer mismatch: %s", $realtime, what);
  endtask

  // Line store behaviour: CR ignored, LF flushes (forwarding if enabled), overflow drops.
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] rx, input logic fwd);
    framed_byte_t fb;
    int unsigned  i;
    if (rx == CHAR_LF) begin
      if (held_count != 0 && fwd) begin
        for (i = 0; i < held_count; i++) begin
          fb.line_byte  = held_line[i];
          fb.byte_index = IDX_W'(i);
          fb.last_byte  = (i + 1 == held_count);
          expected_bytes.push_back(fb);
        end
        lines_forwarded++;
      end
      held_count = 0;
    end else if (rx != CHAR_CR) begin
      if (held_count < MAX_LINE) begin
        held_line[held_count] = rx;
        held_count++;
      end else begin
        held_count = 0;
      end
    end
  endtask

  task automatic check_line_byte(input framed_byte_t got);
    framed_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h index %0d last %0b",
                                got.line_byte, got.byte_index, got.last_byte));
    end else begin
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.line_byte != want.line_byte)
        report_mismatch($sformatf("line_byte %02h, expected %02h at index %0d",
                                  got.line_byte, want.line_byte, want.byte_index));
      if (got.byte_index != want.byte_index)
        report_mismatch($sformatf("byte_index %0d, expected %0d",
                                  got.byte_index, want.byte_index));
      if (got.last_byte != want.last_byte)
        report_mismatch($sformatf("last_byte %0b, expected %0b at index %0d",
                                  got.last_byte, want.last_byte, want.byte_index));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      expected_bytes.delete();
    end else begin
      if (in_valid && in_ready)
        absorb_rx_byte(in_rx_byte, in_forward_enable);
      if (out_valid && out_ready)
        check_line_byte(framed_byte_t'{out_line_byte, out_byte_index, out_last_byte});
    end
    pending_count = expected_bytes.size();
  end

endmodule

// ----- verif/tb_uart_line_framer.sv -----
// tb_uart_line_framer: top level of the line framer testbench; drives requests and gives the verdict.
// Depends on ulf_pkg, uart_line_framer and the ulf_line_checker module.
`timescale 1ns / 1ps

module tb_uart_line_framer;
  import ulf_pkg::*;

  // Enough random non-CR requests to give a few dozen completed lines.
  localparam int RANDOM_REQUESTS = 380;
  // The receiver's long hold-off, long enough for the framer to fill and push back.
  localparam int HOLD_CYCLES     = 500;
  // Far beyond the slowest correct run.
  localparam int CYCLE_LIMIT     = 400000;
  // Cycles allowed after the last expected byte for any stray output to show itself.
  localparam int DRAIN_CYCLES    = 64;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              in_forward_enable = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_line_byte;
  logic [IDX_W-1:0]  out_byte_index;
  logic              out_last_byte;

  int fail_count;
  int pending_count;
  int lines_forwarded;
  int bytes_checked;

  // Sender bookkeeping. CRs are counted apart, since the framer simply discards them.
  int requests_sent = 0;
  int crs_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // The stimulus process raises hold_requests; the receiver serves each one with a long stall.
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int pattern_mode = 0;
  int pattern_pos = 0;
  logic [15:0] stall_pattern = '1;

  always #2 clk = ~clk;

  uart_line_framer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_forward_enable (in_forward_enable),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_byte     (out_line_byte),
    .out_byte_index    (out_byte_index),
    .out_last_byte     (out_last_byte)
  );

  ulf_line_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_forward_enable (in_forward_enable),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_byte     (out_line_byte),
    .out_byte_index    (out_byte_index),
    .out_last_byte     (out_last_byte),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .lines_forwarded   (lines_forwarded),
    .bytes_checked     (bytes_checked)
  );

  // Global watchdog: a hung handshake ends the run here rather than never.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with %0d bytes outstanding.",
               cycle_count, pending_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one request to the framer. The sender works in bursts: when a burst runs out, valid
  // drops for a random gap before the next burst begins. Valid is only ever changed on the
  // falling edge, and in_ready is read straight after the rising edge, so it is the value that
  // the edge itself saw.
  task automatic offer_request(input logic [BYTE_W-1:0] rx, input logic fwd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_rx_byte        <= rx;
    in_forward_enable <= fwd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rx == CHAR_CR)
      crs_sent++;
    else
      requests_sent++;
  endtask

  // Any byte except a line feed, so that a line is not cut short by its own content.
  // Carriage returns may still turn up, and the framer must skip them mid-line.
  function automatic logic [BYTE_W-1:0] random_payload_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CHAR_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Receiver. It normally follows a stall pattern that is redrawn when pattern_left runs out:
  // always ready, a random 16-bit pattern, or a sparse pattern that is mostly stalled.
  // When the stimulus asks for a hold-off it drops ready for HOLD_CYCLES, counted here.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode  = $urandom_range(0, 2);
          stall_pattern = 16'($urandom());
          if (pattern_mode == 2)
            stall_pattern = stall_pattern & 16'($urandom()) & 16'($urandom());
          if (stall_pattern == '0)
            stall_pattern = 16'h0001;
          pattern_left = $urandom_range(20, 80);
        end
        pattern_left--;
        pattern_pos = (pattern_pos + 1) % 16;
        out_ready <= (pattern_mode == 0) ? 1'b1 : stall_pattern[pattern_pos];
      end
    end
  end

  initial begin
    int line_no;
    int kind;
    int seq_len;
    int k;
    int sel;
    int directed_sent;

    // Synchronous reset, held from time zero and released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening. A lone CR and a LF with nothing stored must produce nothing.
    offer_request(CHAR_CR, 1'b0);
    offer_request(CHAR_LF, 1'b1);
    // A short line with both byte extremes, a zero byte and a CR in the middle of it.
    offer_request(8'h00, 1'b1);
    offer_request(8'hFF, 1'b0);
    offer_request(CHAR_CR, 1'b1);
    offer_request(8'h55, 1'b1);
    offer_request(CHAR_CR, 1'b0);
    offer_request(CHAR_LF, 1'b1);
    // A line ended while forwarding is disabled is thrown away...
    offer_request(8'hAA, 1'b1);
    offer_request(8'h7F, 1'b1);
    offer_request(CHAR_LF, 1'b0);
    // ...so the following LF finds the store empty again.
    offer_request(CHAR_LF, 1'b1);
    // A single-byte line, then a line of codes that sit next to CR and LF.
    offer_request(8'h80, 1'b0);
    offer_request(CHAR_LF, 1'b1);
    offer_request(8'h09, 1'b0);
    offer_request(8'h0B, 1'b1);
    offer_request(8'h0C, 1'b0);
    offer_request(8'h0E, 1'b1);
    offer_request(8'h01, 1'b0);
    offer_request(8'hFE, 1'b1);
    offer_request(CHAR_LF, 1'b1);
    // A LF with forwarding off and an empty store.
    offer_request(CHAR_LF, 1'b0);
    directed_sent = requests_sent;

    // Random part. Most requests form proper lines with random content: a payload, an
    // optional CR and a closing LF. The first two lines are pinned to exactly fill the
    // store and to overflow it by one byte. The rest mixes short lines, near-full lines,
    // overlong lines that overflow, and short runs of noise.
    line_no = 0;
    while (requests_sent < directed_sent + RANDOM_REQUESTS) begin
      // Two long receiver hold-offs, taken while the sender carries on.
      if (hold_requests < 2 &&
          requests_sent >= directed_sent + 120 * (hold_requests + 1))
        hold_requests++;
      kind = $urandom_range(0, 9);
      if (line_no == 0)
        seq_len = MAX_LINE_DEF;
      else if (line_no == 1)
        seq_len = MAX_LINE_DEF + 1;
      else if (kind == 9)
        seq_len = $urandom_range(MAX_LINE_DEF + 1, MAX_LINE_DEF + 8);
      else if (kind == 7)
        seq_len = $urandom_range(MAX_LINE_DEF - 6, MAX_LINE_DEF);
      else
        seq_len = $urandom_range(1, 10);

      if (kind == 8 && line_no > 1) begin
        // Noise: stray LFs, CRs and arbitrary bytes with a random enable level.
        for (k = 0; k < $urandom_range(1, 6); k++) begin
          sel = $urandom_range(0, 3);
          if (sel == 0)
            offer_request(CHAR_LF, 1'($urandom_range(0, 1)));
          else if (sel == 1)
            offer_request(CHAR_CR, 1'($urandom_range(0, 1)));
          else
            offer_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end else begin
        for (k = 0; k < seq_len; k++)
          offer_request(random_payload_byte(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          offer_request(CHAR_CR, 1'($urandom_range(0, 1)));
        // Most lines are forwarded; roughly one in six is dropped.
        offer_request(CHAR_LF, $urandom_range(0, 5) != 0);
      end
      line_no++;
    end

    // Stop offering and let every expected byte arrive, then watch a little longer.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d framer requests (%0d of them CR) in %0d random sequences.",
             requests_sent + crs_sent, crs_sent, line_no);
    $display("It forwarded %0d lines and checked %0d line bytes, with %0d mismatches.",
             lines_forwarded, bytes_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ulf_pkg.sv
rtl/ulf_ram.sv
rtl/ulf_front.sv
rtl/ulf_queue.sv
rtl/ulf_back.sv
rtl/uart_line_framer.sv
verif/ulf_line_checker.sv
verif/tb_uart_line_framer.sv
